@@ hdl/pftp_pkg.sv @@
package pftp_pkg;

    typedef struct packed {
        logic signed [31:0] point_a_x;
        logic signed [31:0] point_a_y;
        logic signed [31:0] point_a_z;
        logic signed [31:0] point_b_x;
        logic signed [31:0] point_b_y;
        logic signed [31:0] point_b_z;
        logic signed [31:0] point_c_x;
        logic signed [31:0] point_c_y;
        logic signed [31:0] point_c_z;
    } pftp_in_t;

    typedef struct packed {
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] normal_z;
        logic signed [39:0] plane_offset;
        logic               degenerate;
        logic               offset_saturated;
    } pftp_out_t;

    // Cross-product magnitude width (edges 33 bits signed, products 66, difference 67)
    localparam int CROSS_W = 67;
    localparam int MAG_W   = 66;
    localparam int LEN_W   = 7;
    // Square root: 32 result bits, one bit per stage
    localparam int SQRT_STEPS = 32;
    // Divide: quotient up to 31 bits, one bit per stage
    localparam int DIV_STEPS = 31;

    // Bit length of a magnitude
    function automatic logic [LEN_W-1:0] bit_len(input logic [MAG_W-1:0] v);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (v[i]) n = LEN_W'(i + 1);
        end
        return n;
    endfunction

endpackage

@@ hdl/pftp_norm_div.sv @@
// Restoring divide, one quotient bit per stage: q = (u*2^30 + r/2) / r
module pftp_norm_div
    import pftp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic [61:0] numer,
    input  logic [31:0] denom,
    output logic [30:0] quot
);

    logic [62:0] rem_reg [DIV_STEPS+1];
    logic [31:0] den_reg [DIV_STEPS+1];
    logic [30:0] q_reg   [DIV_STEPS+1];

    // Stage zero is the operand load
    always_comb begin
        rem_reg[0] = {1'b0, numer};
        den_reg[0] = denom;
        q_reg[0]   = '0;
    end

    // Advance one quotient bit per stage, MSB first
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        localparam int SH = DIV_STEPS - 1 - k;
        logic [62:0] trial;
        logic        fits;
        logic [30:0] qn;
        always_comb begin
            trial = 63'({den_reg[k], 31'b0} >> (31 - SH));
            fits  = rem_reg[k] >= trial;
            qn    = q_reg[k];
            qn[SH] = fits;
        end
        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                q_reg[k+1] <= '0;
            end else if (advance) begin
                q_reg[k+1] <= qn;
            end
        end
        always_ff @(posedge clk) begin
            if (advance) begin
                rem_reg[k+1] <= fits ? rem_reg[k] - trial : rem_reg[k];
                den_reg[k+1] <= den_reg[k];
            end
        end
    end

    assign quot = q_reg[DIV_STEPS];

endmodule

@@ hdl/plane_from_three_points_core.sv @@
// Channel | Direction | Handshake        | Payload
// in      | input     | in_valid/in_stall   | pftp_in_t
// out     | output    | out_valid/out_stall | pftp_out_t
//
// Fully pipelined: one transaction per cycle while the output is not stalled.
// Stages, in order: edge/cross/normalize, sum of squares, square root, divide, offset/output.
// Latency is set by the bit-serial root and divide stage chains.
// Reset clears every stage valid bit; payload registers are not reset, except the divider quotients.
// A stall at the output freezes the whole pipeline, so nothing is lost or repeated.
module plane_from_three_points_core
    import pftp_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  pftp_in_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output pftp_out_t out_data
);

    localparam int SQ_BASE = 4;
    localparam int NS = SQ_BASE + SQRT_STEPS + 1 + DIV_STEPS + 4;

    logic advance;
    logic v_reg [NS];

    // Hold all stages while the final stage is stalled with data
    assign advance  = !(v_reg[NS-1] && out_stall);
    assign in_stall = !advance;
    assign out_valid = v_reg[NS-1];

    // Valid bits travel with data
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < NS; i++) v_reg[i] <= 1'b0;
        end else if (advance) begin
            v_reg[0] <= in_valid;
            for (int i = 1; i < NS; i++) v_reg[i] <= v_reg[i-1];
        end
    end

    // Stage 1: edge vectors
    logic signed [32:0] e_reg [3];
    logic signed [32:0] f_reg [3];
    logic signed [31:0] a1_reg [3];
    always_ff @(posedge clk) begin
        if (advance) begin
            a1_reg[0] <= in_data.point_a_x;
            a1_reg[1] <= in_data.point_a_y;
            a1_reg[2] <= in_data.point_a_z;
            e_reg[0] <= 33'(in_data.point_b_x) - 33'(in_data.point_a_x);
            e_reg[1] <= 33'(in_data.point_b_y) - 33'(in_data.point_a_y);
            e_reg[2] <= 33'(in_data.point_b_z) - 33'(in_data.point_a_z);
            f_reg[0] <= 33'(in_data.point_c_x) - 33'(in_data.point_a_x);
            f_reg[1] <= 33'(in_data.point_c_y) - 33'(in_data.point_a_y);
            f_reg[2] <= 33'(in_data.point_c_z) - 33'(in_data.point_a_z);
        end
    end

    // Stage 2: six partial products (33x33)
    logic signed [65:0] pp_reg [6];
    logic signed [31:0] a2_reg [3];
    always_ff @(posedge clk) begin
        if (advance) begin
            a2_reg <= a1_reg;
            pp_reg[0] <= e_reg[1] * f_reg[2];
            pp_reg[1] <= e_reg[2] * f_reg[1];
            pp_reg[2] <= e_reg[2] * f_reg[0];
            pp_reg[3] <= e_reg[0] * f_reg[2];
            pp_reg[4] <= e_reg[0] * f_reg[1];
            pp_reg[5] <= e_reg[1] * f_reg[0];
        end
    end

    // Stage 3: cross product, sign and magnitude
    logic signed [CROSS_W-1:0] cr [3];
    logic [MAG_W-1:0] mag_reg [3];
    logic             neg3_reg [3];
    logic signed [31:0] a3_reg [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cr[i] = CROSS_W'(pp_reg[2*i]) - CROSS_W'(pp_reg[2*i+1]);
        end
    end
    always_ff @(posedge clk) begin
        if (advance) begin
            a3_reg <= a2_reg;
            for (int i = 0; i < 3; i++) begin
                neg3_reg[i] <= cr[i][CROSS_W-1];
                mag_reg[i]  <= cr[i][CROSS_W-1] ? MAG_W'(-cr[i]) : MAG_W'(cr[i]);
            end
        end
    end

    // Stage 4: common shift to 31 bits
    logic [LEN_W-1:0] l0, l1, l2, lmax;
    logic [MAG_W+30:0] wide [3];
    logic [30:0] u [3];
    always_comb begin
        l0 = bit_len(mag_reg[0]);
        l1 = bit_len(mag_reg[1]);
        l2 = bit_len(mag_reg[2]);
        lmax = l0;
        if (l1 > lmax) lmax = l1;
        if (l2 > lmax) lmax = l2;
        for (int i = 0; i < 3; i++) begin
            wide[i] = {mag_reg[i], 31'b0} >> lmax;
            u[i] = wide[i][30:0];
        end
    end
    logic [30:0] u4_reg [3];
    logic        neg4_reg [3];
    logic        dg4_reg;
    logic signed [31:0] a4_reg [3];
    always_ff @(posedge clk) begin
        if (advance) begin
            a4_reg <= a3_reg;
            neg4_reg <= neg3_reg;
            u4_reg <= u;
            dg4_reg <= (lmax == '0);
        end
    end

    // Sum of squares, registered after the multipliers
    logic [63:0] s_reg;
    logic [30:0] u5_reg [3];
    logic        neg5_reg [3];
    logic        dg5_reg;
    logic signed [31:0] a5_reg [3];
    always_ff @(posedge clk) begin
        if (advance) begin
            a5_reg <= a4_reg;
            neg5_reg <= neg4_reg;
            u5_reg <= u4_reg;
            dg5_reg <= dg4_reg;
            s_reg <= 64'(u4_reg[0]) * 64'(u4_reg[0]) + 64'(u4_reg[1]) * 64'(u4_reg[1])
                   + 64'(u4_reg[2]) * 64'(u4_reg[2]);
        end
    end

    // Square root, one result bit per stage
    logic [63:0] sr_rem [SQRT_STEPS+1];
    logic [31:0] sr_root [SQRT_STEPS+1];
    logic [30:0] su [SQRT_STEPS+1][3];
    logic        sn [SQRT_STEPS+1][3];
    logic        sdg [SQRT_STEPS+1];
    logic signed [31:0] sa [SQRT_STEPS+1][3];
    always_comb begin
        sr_rem[0] = s_reg;
        sr_root[0] = '0;
        su[0] = u5_reg;
        sn[0] = neg5_reg;
        sdg[0] = dg5_reg;
        sa[0] = a5_reg;
    end
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        localparam int B = SQRT_STEPS - 1 - k;
        logic [63:0] trial;
        logic [31:0] cand;
        always_comb begin
            cand = sr_root[k] | (32'd1 << B);
            trial = 64'(cand) * 64'(cand);
        end
        always_ff @(posedge clk) begin
            if (advance) begin
                sr_root[k+1] <= (trial <= sr_rem[k]) ? cand : sr_root[k];
                sr_rem[k+1]  <= sr_rem[k];
                su[k+1] <= su[k];
                sn[k+1] <= sn[k];
                sdg[k+1] <= sdg[k];
                sa[k+1] <= sa[k];
            end
        end
    end

    // Divider operands, one per component
    logic [30:0] q [3];
    logic [31:0] r_fix;
    assign r_fix = (sr_root[SQRT_STEPS] == '0) ? 32'd1 : sr_root[SQRT_STEPS];
    for (genvar c = 0; c < 3; c++) begin : g_div
        pftp_norm_div u_div (
            .clk    (clk),
            .rst_n  (rst_n),
            .advance(advance),
            .numer  (62'({su[SQRT_STEPS][c], 30'b0}) + 62'(r_fix >> 1)),
            .denom  (r_fix),
            .quot   (q[c])
        );
    end

    // Carry sign, flag and point A alongside the divide
    logic        dn [DIV_STEPS+1][3];
    logic        ddg [DIV_STEPS+1];
    logic signed [31:0] da [DIV_STEPS+1][3];
    always_comb begin
        dn[0] = sn[SQRT_STEPS];
        ddg[0] = sdg[SQRT_STEPS];
        da[0] = sa[SQRT_STEPS];
    end
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_side
        always_ff @(posedge clk) begin
            if (advance) begin
                dn[k+1] <= dn[k];
                ddg[k+1] <= ddg[k];
                da[k+1] <= da[k];
            end
        end
    end

    // Signed normal
    logic signed [31:0] n_reg [3];
    logic signed [31:0] oa_reg [3];
    logic dg_n_reg;
    always_ff @(posedge clk) begin
        if (advance) begin
            oa_reg <= da[DIV_STEPS];
            dg_n_reg <= ddg[DIV_STEPS];
            for (int i = 0; i < 3; i++) begin
                n_reg[i] <= ddg[DIV_STEPS] ? 32'sd0
                          : (dn[DIV_STEPS][i] ? -$signed({1'b0, q[i]}) : $signed({1'b0, q[i]}));
            end
        end
    end

    // Products n_i * a_i
    logic signed [63:0] np_reg [3];
    logic signed [31:0] n2_reg [3];
    logic dg_p_reg;
    always_ff @(posedge clk) begin
        if (advance) begin
            n2_reg <= n_reg;
            dg_p_reg <= dg_n_reg;
            for (int i = 0; i < 3; i++) np_reg[i] <= 64'(n_reg[i]) * 64'(oa_reg[i]);
        end
    end

    // Sum, round half up, scale
    logic signed [65:0] p_sum;
    logic signed [65:0] t_round;
    logic signed [35:0] d_reg;
    logic signed [31:0] n3_reg [3];
    logic dg_d_reg;
    always_comb begin
        p_sum = 66'(np_reg[0]) + 66'(np_reg[1]) + 66'(np_reg[2]);
        t_round = -p_sum + 66'sd536870912;
    end
    always_ff @(posedge clk) begin
        if (advance) begin
            n3_reg <= n2_reg;
            dg_d_reg <= dg_p_reg;
            d_reg <= 36'(t_round >>> 30);
        end
    end

    // Output register; degenerate results get a zero offset
    pftp_out_t o_reg;
    always_ff @(posedge clk) begin
        if (advance) begin
            o_reg.normal_x <= n3_reg[0];
            o_reg.normal_y <= n3_reg[1];
            o_reg.normal_z <= n3_reg[2];
            o_reg.degenerate <= dg_d_reg;
            o_reg.plane_offset <= dg_d_reg ? 40'sd0 : 40'(d_reg);
            o_reg.offset_saturated <= 1'b0;
        end
    end
    assign out_data = o_reg;

endmodule

@@ hdl/pftp_checker.sv @@
module pftp_checker
    import pftp_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      in_stall,
    input logic      out_valid,
    input logic      out_stall,
    input pftp_out_t out_data
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    a_stall_path: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("input stall mismatch");

    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.degenerate |-> out_data.normal_x == 0
            && out_data.normal_y == 0 && out_data.normal_z == 0
            && out_data.plane_offset == 0)
        else $error("degenerate result not zero");

    a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.normal_x <= 32'sd1073741824
            && out_data.normal_x >= -32'sd1073741824)
        else $error("normal out of range");

endmodule

bind plane_from_three_points_core pftp_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import pftp_pkg::*;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    pftp_in_t  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    pftp_out_t out_data;

    pftp_out_t planes_pending[$];
    int        error_count = 0;
    bit        idle_enable = 1'b1;

    plane_from_three_points_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Guard against a hung pipeline
    initial
    begin
        #5ms;
        $display("status: fail");
        $finish;
    end

    // Floor square root of a 64-bit value
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] root;
        logic [63:0] bitv;
        rem  = v;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > rem)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (rem >= root + bitv)
            begin
                rem  = rem - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Unit normal and offset of the plane through the three points
    function automatic pftp_out_t plane_of(input pftp_in_t pt);
        logic signed [31:0] pa[3], pb[3], pc[3];
        logic signed [67:0] ew[3], fw[3], cr[3];
        logic [67:0]        mag[3];
        logic               neg[3];
        logic [31:0]        u[3];
        logic [63:0]        sq_sum, root, q;
        logic signed [63:0] nv[3], aw[3], dot;
        logic signed [65:0] tw, dw;
        int                 maxbl, bl, sh;
        pftp_out_t          res;
        pa = '{pt.point_a_x, pt.point_a_y, pt.point_a_z};
        pb = '{pt.point_b_x, pt.point_b_y, pt.point_b_z};
        pc = '{pt.point_c_x, pt.point_c_y, pt.point_c_z};
        res = '0;
        for (int i = 0; i < 3; i++)
        begin
            aw[i] = pa[i];
            ew[i] = pb[i];
            ew[i] = ew[i] - aw[i];
            fw[i] = pc[i];
            fw[i] = fw[i] - aw[i];
        end
        cr[0] = ew[1] * fw[2] - ew[2] * fw[1];
        cr[1] = ew[2] * fw[0] - ew[0] * fw[2];
        cr[2] = ew[0] * fw[1] - ew[1] * fw[0];
        maxbl = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = cr[i][67];
            mag[i] = neg[i] ? -cr[i] : cr[i];
            bl = 0;
            for (int k = 0; k < 68; k++)
                if (mag[i][k])
                    bl = k + 1;
            if (bl > maxbl)
                maxbl = bl;
        end
        // Collinear points give no plane
        if (maxbl == 0)
        begin
            res.degenerate = 1'b1;
            return res;
        end
        sh = maxbl - 31;
        sq_sum = '0;
        for (int i = 0; i < 3; i++)
        begin
            if (sh > 0)
                u[i] = 32'(mag[i] >> sh);
            else
                u[i] = 32'(mag[i] << (-sh));
            sq_sum = sq_sum + {32'd0, u[i]} * {32'd0, u[i]};
        end
        root = floor_sqrt(sq_sum);
        dot = '0;
        for (int i = 0; i < 3; i++)
        begin
            q = (({32'd0, u[i]} << 30) + (root >> 1)) / root;
            nv[i] = neg[i] ? -$signed(q) : $signed(q);
            dot = dot + nv[i] * aw[i];
        end
        // Round half up to Q.16, then clip
        tw = dot;
        tw = -tw + (66'sd1 <<< 29);
        dw = tw >>> 30;
        if (dw > 66'sd549755813887)
        begin
            dw = 66'sd549755813887;
            res.offset_saturated = 1'b1;
        end
        if (dw < -66'sd549755813888)
        begin
            dw = -66'sd549755813888;
            res.offset_saturated = 1'b1;
        end
        res.normal_x     = nv[0][31:0];
        res.normal_y     = nv[1][31:0];
        res.normal_z     = nv[2][31:0];
        res.plane_offset = dw[39:0];
        return res;
    endfunction

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        if (!idle_enable)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 94)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Send one transaction and queue its expected plane
    task automatic send_points(input pftp_in_t pt);
        int gap;
        gap = idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= pt;
        do
            @(posedge clk);
        while (in_stall);
        planes_pending.push_back(plane_of(pt));
    endtask

    task automatic send_xyz(input logic [31:0] ax, ay, az, bx, by, bz, cx, cy, cz);
        pftp_in_t pt;
        pt = {ax, ay, az, bx, by, bz, cx, cy, cz};
        send_points(pt);
    endtask

    // Check each accepted result against the oldest expectation
    always @(posedge clk)
    begin
        pftp_out_t exp_pl;
        if (rst_n && out_valid && !out_stall)
        begin
            if (planes_pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $time, out_data);
                error_count++;
            end
            else
            begin
                exp_pl = planes_pending.pop_front();
                if (out_data.normal_x !== exp_pl.normal_x)
                begin
                    $display("%0t: normal_x exp %0d got %0d", $time,
                             exp_pl.normal_x, out_data.normal_x);
                    error_count++;
                end
                if (out_data.normal_y !== exp_pl.normal_y)
                begin
                    $display("%0t: normal_y exp %0d got %0d", $time,
                             exp_pl.normal_y, out_data.normal_y);
                    error_count++;
                end
                if (out_data.normal_z !== exp_pl.normal_z)
                begin
                    $display("%0t: normal_z exp %0d got %0d", $time,
                             exp_pl.normal_z, out_data.normal_z);
                    error_count++;
                end
                if (out_data.plane_offset !== exp_pl.plane_offset)
                begin
                    $display("%0t: plane_offset exp %0d got %0d", $time,
                             exp_pl.plane_offset, out_data.plane_offset);
                    error_count++;
                end
                if (out_data.degenerate !== exp_pl.degenerate)
                begin
                    $display("%0t: degenerate exp %0b got %0b", $time,
                             exp_pl.degenerate, out_data.degenerate);
                    error_count++;
                end
                if (out_data.offset_saturated !== exp_pl.offset_saturated)
                begin
                    $display("%0t: offset_saturated exp %0b got %0b", $time,
                             exp_pl.offset_saturated, out_data.offset_saturated);
                    error_count++;
                end
            end
        end
        // Stall the output now and then
        if (!idle_enable)
            out_stall <= 1'b0;
        else if ($urandom_range(0, 99) < 70)
            out_stall <= 1'b0;
        else if ($urandom_range(0, 9) < 9)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(0, 3) != 0);
    end

    // Pick a coordinate biased toward the extremes
    function automatic logic [31:0] edge_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    task automatic test_directed();
        send_xyz(0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_xyz(32'h10000, 32'h20000, 32'h30000, 32'h10000, 32'h20000, 32'h30000,
                 32'h10000, 32'h20000, 32'h30000);
        // Axis planes
        send_xyz(0, 0, 32'h10000, 32'h10000, 0, 32'h10000, 0, 32'h10000, 32'h10000);
        send_xyz(0, 32'hFFFF0000, 0, 0, 32'hFFFF0000, 32'h10000, 32'h10000,
                 32'hFFFF0000, 0);
        send_xyz(32'h50000, 0, 0, 32'h50000, 32'h10000, 0, 32'h50000, 0, 32'h10000);
        // Collinear on a line
        send_xyz(0, 0, 0, 32'h10000, 32'h10000, 32'h10000, 32'h20000, 32'h20000,
                 32'h20000);
        // Extremes of every coordinate
        send_xyz(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000);
        send_xyz(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h7FFF_FFFF);
        send_xyz(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF);
        send_xyz(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000);
        // Tiny cross product, left shift path
        send_xyz(0, 0, 0, 1, 0, 0, 0, 1, 0);
        send_xyz(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF);
        // Largest offset with a far first point
        send_xyz(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFE,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFE,
                 32'h7FFF_FFFF);
        send_xyz(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0001,
                 32'h8000_0001, 32'h8000_0000, 32'h8000_0000, 32'h8000_0001,
                 32'h8000_0001);
        // Coincident points at the extremes
        send_xyz(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000);
    endtask

    task automatic test_random_full(input int count);
        for (int n = 0; n < count; n++)
            send_xyz($urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                     $urandom(), $urandom(), $urandom(), $urandom());
    endtask

    // Small triangles around a random anchor
    task automatic test_random_local(input int count);
        logic [31:0] base[3];
        logic [31:0] span;
        for (int n = 0; n < count; n++)
        begin
            span = 32'd1 << $urandom_range(0, 24);
            for (int i = 0; i < 3; i++)
                base[i] = $urandom();
            send_xyz(base[0], base[1], base[2],
                     base[0] + ($urandom() % span) - span / 2,
                     base[1] + ($urandom() % span) - span / 2,
                     base[2] + ($urandom() % span) - span / 2,
                     base[0] + ($urandom() % span) - span / 2,
                     base[1] + ($urandom() % span) - span / 2,
                     base[2] + ($urandom() % span) - span / 2);
        end
    endtask

    // Points along a line, some nudged off it
    task automatic test_collinear(input int count);
        logic [31:0] base[3], dir[3], nudge;
        int          k, m;
        for (int n = 0; n < count; n++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                base[i] = $urandom_range(0, 32'h3FFF_FFFF) - 32'h2000_0000;
                dir[i]  = $urandom_range(0, 32'h1FFFF) - 32'h10000;
            end
            k = $urandom_range(0, 100) - 50;
            m = $urandom_range(0, 100) - 50;
            nudge = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
            send_xyz(base[0], base[1], base[2],
                     base[0] + k * dir[0], base[1] + k * dir[1], base[2] + k * dir[2],
                     base[0] + m * dir[0] + nudge, base[1] + m * dir[1],
                     base[2] + m * dir[2]);
        end
    endtask

    task automatic test_extremes(input int count);
        for (int n = 0; n < count; n++)
            send_xyz(edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                     edge_coord(), edge_coord(), edge_coord(), edge_coord(),
                     edge_coord());
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_full(500);
        // Back-to-back stretch with no idling
        idle_enable = 1'b0;
        test_random_full(200);
        idle_enable = 1'b1;
        test_random_local(350);
        test_collinear(200);
        test_extremes(150);
        in_valid <= 1'b0;

        // Drain, then let the pipeline settle
        while (planes_pending.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);

        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
